[hw/rtl/urlpd_pkg.sv]
package urlpd_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   // One classified input word: up to three output bytes, first byte in slot 0.
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] bytes;
      logic            last;
   } entry_type;

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c inside {[8'h30:8'h39]}) begin
         v = c - 8'h30;
      end else if (c inside {[8'h61:8'h66]}) begin
         v = c - 8'h57;
      end else if (c inside {[8'h41:8'h46]}) begin
         v = c - 8'h37;
      end
      hex_nibble = v[3:0];
   endfunction

   function automatic logic [7:0] map_literal(input logic [7:0] c, input logic form_mode);
      map_literal = (form_mode && (c == CHAR_PLUS)) ? CHAR_SPACE : c;
   endfunction

endpackage

[hw/rtl/urlpd_front.sv]
module urlpd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 form_mode,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   output urlpd_pkg::entry_type entry
);

   localparam logic [1:0] PHASE_IDLE    = 2'd0;
   localparam logic [1:0] PHASE_PERCENT = 2'd1;
   localparam logic [1:0] PHASE_DIGIT   = 2'd2;
   localparam logic [1:0] PHASE_PASS    = 2'd3;

   logic [1:0] phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic       hex;
   logic [7:0] lit;

   assign hex = urlpd_pkg::is_hex(in_byte);
   assign lit = urlpd_pkg::map_literal(in_byte, form_mode);

   always_comb begin
      phase_in    = phase_ff;
      held_in     = held_ff;
      entry.count = 2'd0;
      entry.bytes = '0;
      entry.last  = in_last;
      case (phase_ff)
         PHASE_IDLE: begin
            if ((in_byte == urlpd_pkg::CHAR_PERCENT) && !in_last) begin
               phase_in = PHASE_PERCENT;
            end else begin
               entry.count    = 2'd1;
               entry.bytes[0] = lit;
            end
         end
         PHASE_PERCENT: begin
            if (hex && !in_last) begin
               held_in  = in_byte;
               phase_in = PHASE_DIGIT;
            end else begin
               entry.count    = 2'd2;
               entry.bytes[0] = urlpd_pkg::CHAR_PERCENT;
               entry.bytes[1] = lit;
               phase_in       = hex ? PHASE_IDLE : PHASE_PASS;
            end
         end
         PHASE_DIGIT: begin
            if (hex) begin
               entry.count    = 2'd1;
               entry.bytes[0] = {urlpd_pkg::hex_nibble(held_ff),
                                 urlpd_pkg::hex_nibble(in_byte)};
            end else begin
               entry.count    = 2'd3;
               entry.bytes[0] = urlpd_pkg::CHAR_PERCENT;
               entry.bytes[1] = urlpd_pkg::map_literal(held_ff, form_mode);
               entry.bytes[2] = lit;
            end
            phase_in = PHASE_IDLE;
         end
         default: begin
            entry.count    = 2'd1;
            entry.bytes[0] = lit;
            phase_in       = PHASE_IDLE;
         end
      endcase
      // The end of a string always leaves the escape state clean.
      if (in_last) begin
         phase_in = PHASE_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         held_ff  <= 8'h00;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

[hw/rtl/urlpd_queue.sv]
module urlpd_queue #(
   parameter int DEPTH = urlpd_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  urlpd_pkg::entry_type push_entry,
   input  logic                 pop,
   output urlpd_pkg::entry_type head,
   output logic                 empty,
   output logic                 full
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   urlpd_pkg::entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [COUNT_W-1:0]   count_ff;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign empty = (count_ff == '0);
   assign full  = (count_ff == COUNT_W'(DEPTH));
   assign head  = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Entries in the queue always carry at least one byte.
   always_ff @(posedge clock) begin
      if (!reset && push && (push_entry.count == 2'd0)) begin
         $error("queue: empty entry pushed");
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue: push while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue: pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("queue: occupancy out of range");

endmodule

[hw/rtl/urlpd_back.sv]
module urlpd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  urlpd_pkg::entry_type head,
   input  logic                 head_valid,
   output logic                 pop,
   output logic                 out_valid,
   input  logic                 out_stall,
   output logic [7:0]           out_byte,
   output logic                 out_last
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       load, take, end_of_entry;

   assign load         = !valid_ff || !out_stall;
   assign take         = load && head_valid;
   assign end_of_entry = (idx_ff == 2'(head.count - 2'd1));
   assign pop          = take && end_of_entry;

   always_comb begin
      case (idx_ff)
         2'd0:    byte_in = head.bytes[0];
         2'd1:    byte_in = head.bytes[1];
         default: byte_in = head.bytes[2];
      endcase
      last_in  = head.last && end_of_entry;
      valid_in = take ? 1'b1 : (load ? 1'b0 : valid_ff);
      idx_in   = idx_ff;
      if (take) begin
         idx_in = end_of_entry ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

endmodule

[hw/rtl/url_percent_decoder.sv]
// URL percent decoder. Raw string bytes enter one word per cycle on the req_ channel,
// with req_in_last on the final byte, and decoded bytes leave on the rsp_ channel with
// rsp_out_last on the final decoded byte. A '%' and two hex digits of either case become
// one byte; a malformed escape passes its bytes through literally (a '%' among them does
// not open a new escape), and an escape cut short by the end of the string is flushed.
// With csr_write_data written as 1, every literal '+' leaves as a space; write the mode
// only while the block is idle. Rate: the front takes one input word per cycle and the
// back emits one output byte per cycle, so a string streams at one word per cycle as long
// as each input word yields at most one byte and rsp_stall stays low; a malformed escape
// that emits two or three bytes at once holds the back on its entry until every byte has
// left, and the input stalls once the queue of QUEUE_DEPTH entries between front and back
// is full. The first byte that an input word yields passes through the queue entry and
// then the output register before it appears on rsp_.
module url_percent_decoder #(
   parameter int QUEUE_DEPTH = urlpd_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   // Configuration: the form mode bit.
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   // Encoded input words.
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   // Decoded output words.
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   logic                 form_mode_ff;
   logic                 accept;
   logic                 push;
   logic                 pop;
   logic                 q_empty;
   logic                 q_full;
   urlpd_pkg::entry_type front_entry;
   urlpd_pkg::entry_type q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         form_mode_ff <= 1'b0;
      end else if (csr_write_enable) begin
         form_mode_ff <= csr_write_data;
      end
   end

   // The front only needs queue room; a word that is absorbed into an escape
   // pushes nothing but is still held back while the queue is full.
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign push      = accept && (front_entry.count != 2'd0);

   // The front tracks the escape phase and turns each word into zero to three bytes.
   urlpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .form_mode (form_mode_ff),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .in_last   (req_in_last),
      .entry     (front_entry)
   );

   // The queue decouples classification from byte emission.
   urlpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (front_entry),
      .pop        (pop),
      .head       (q_head),
      .empty      (q_empty),
      .full       (q_full)
   );

   // The back walks the bytes of the head entry into the output register.
   urlpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .head_valid (!q_empty),
      .pop        (pop),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_byte   (rsp_out_byte),
      .out_last   (rsp_out_last)
   );

endmodule
